[hdl/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants
// Line and row formats, command codes and controller commands for the
// set-associative tag and LRU controller.
// ----------------------------------------------------------------------------
package salc_pkg;

	localparam int MAX_SETS  = 256;
	localparam int MAX_WAYS  = 8;
	localparam int ADDR_BITS = 32;
	localparam int SET_W     = $clog2(MAX_SETS);
	localparam int LANE_W    = $clog2(MAX_WAYS);
	localparam int ROWS      = MAX_SETS;
	localparam int RANK_W    = 3;
	localparam int BASE_W    = SET_W + LANE_W;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_INVAL = 2'd2,
		CMD_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_CACHE_SIZE = 2'd0,
		REG_BLOCK      = 2'd1,
		REG_WAY        = 2'd2,
		REG_WALLOC     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                 valid;
		logic                 dirty;
		logic [RANK_W-1:0]    rank;
		logic [ADDR_BITS-1:0] tag;
		logic [ADDR_BITS-1:0] addr;
	} line_t;

	typedef line_t [MAX_WAYS-1:0] row_t;

	typedef struct packed {
		logic capture;
		logic update;
	} ctl_cmd_t;

endpackage

[hdl/salc_ctrl.sv]
// ----------------------------------------------------------------------------
// salc_ctrl: access sequencer
// Two-state controller: capture an access, then update the set.
// ----------------------------------------------------------------------------
module salc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output salc_pkg::ctl_cmd_t ctl
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOOK = 2'b10
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_LOOK;
				ST_LOOK: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign ctl.capture = (state_q == ST_IDLE) && start;
	assign ctl.update  = (state_q == ST_LOOK);

endmodule

[hdl/salc_datapath.sv]
// ----------------------------------------------------------------------------
// salc_datapath: tag store, LRU update and counters
// Holds the configuration, the set memory with per-row valid flags, and
// computes hit, fill, eviction and rank updates for one set per access.
// ----------------------------------------------------------------------------
module salc_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  salc_pkg::ctl_cmd_t   ctl,
	input  logic [1:0]           cmd,
	input  logic [31:0]          address,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic                 done,
	output logic                 hit,
	output logic                 evicted,
	output logic [31:0]          evicted_address,
	output logic [31:0]          access_total,
	output logic [31:0]          miss_total
);

	localparam int LW = salc_pkg::LANE_W;
	localparam int RW = salc_pkg::RANK_W;

	logic [4:0] cs_q, bb_q;
	logic [1:0] wb_q;
	logic       wa_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= 5'd13;
			bb_q <= 5'd5;
			wb_q <= 2'd1;
			wa_q <= 1'b1;
		end else if (cfg_we) begin
			case (salc_pkg::reg_idx_t'(cfg_index))
				salc_pkg::REG_CACHE_SIZE: cs_q <= cfg_data[4:0];
				salc_pkg::REG_BLOCK:      bb_q <= cfg_data[4:0];
				salc_pkg::REG_WAY:        wb_q <= cfg_data[1:0];
				salc_pkg::REG_WALLOC:     wa_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Address split
	logic [5:0] used;
	logic [4:0] sb;
	logic [31:0] set_full;
	logic [salc_pkg::SET_W-1:0] set_idx;
	logic [salc_pkg::BASE_W-1:0] base;
	logic [5:0] shift;

	always_comb begin
		used = {1'b0, bb_q} + {4'd0, wb_q};
		if ({1'b0, cs_q} > used) sb = 5'({1'b0, cs_q} - used);
		else sb = 5'd0;
		if (sb > 5'(salc_pkg::SET_W)) sb = 5'(salc_pkg::SET_W);
		set_full = (address >> bb_q) & ((32'd1 << sb) - 32'd1);
		set_idx  = set_full[salc_pkg::SET_W-1:0];
		base     = {{LW{1'b0}}, set_idx} << wb_q;
		shift    = {1'b0, bb_q} + {1'b0, sb};
	end

	// Set memory, one row of lanes per read
	salc_pkg::row_t mem [salc_pkg::ROWS];
	logic [salc_pkg::ROWS-1:0] row_ok_q;
	salc_pkg::row_t rd_s1;
	logic rv_s1;
	logic [1:0] cmd_s1;
	logic [31:0] addr_s1, tag_s1;
	logic [salc_pkg::SET_W-1:0] row_s1;
	logic [LW-1:0] off_s1;
	salc_pkg::row_t wr_row;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			rd_s1   <= mem[base[salc_pkg::BASE_W-1:LW]];
			cmd_s1  <= cmd;
			addr_s1 <= address;
			tag_s1  <= address >> shift;
			row_s1  <= base[salc_pkg::BASE_W-1:LW];
			off_s1  <= base[LW-1:0];
		end
		if (ctl.update) mem[row_s1] <= wr_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			rv_s1    <= 1'b0;
		end else begin
			if (ctl.capture) rv_s1 <= row_ok_q[base[salc_pkg::BASE_W-1:LW]];
			if (ctl.update) row_ok_q[row_s1] <= 1'b1;
		end
	end

	// Lookup and update
	salc_pkg::row_t cur;
	logic [LW:0] ways;
	logic [RW-1:0] top_rank, old, min_r;
	logic [salc_pkg::MAX_WAYS-1:0] inset;
	logic f_hit, f_inv, f_ev, do_fill, is_acc;
	logic [LW-1:0] h_lane, i_lane, m_lane, t_lane;
	logic [31:0] ev_addr;

	always_comb begin
		ways     = (LW+1)'(1) << wb_q;
		top_rank = RW'(ways - (LW+1)'(1));
		for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
			cur[i] = rv_s1 ? rd_s1[i] : '0;
			cur[i].tag  = rd_s1[i].tag;
			cur[i].addr = rd_s1[i].addr;
			inset[i] = ((LW+1)'(i) >= {1'b0, off_s1}) &&
			           ((LW+1)'(i) < ({1'b0, off_s1} + ways));
		end
		f_hit = 1'b0; h_lane = '0;
		f_inv = 1'b0; i_lane = '0;
		f_ev  = 1'b0; m_lane = off_s1; min_r = cur[off_s1].rank;
		for (int i = salc_pkg::MAX_WAYS - 1; i >= 0; i--) begin
			if (inset[i] && cur[i].valid && cur[i].tag == tag_s1) begin
				f_hit = 1'b1; h_lane = LW'(i);
			end
			if (inset[i] && !cur[i].valid) begin
				f_inv = 1'b1; i_lane = LW'(i);
			end
		end
		for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
			if (inset[i] && cur[i].rank < min_r) begin
				min_r = cur[i].rank; m_lane = LW'(i);
			end
		end
		is_acc  = (cmd_s1 == salc_pkg::CMD_READ) || (cmd_s1 == salc_pkg::CMD_WRITE);
		do_fill = is_acc && !f_hit && ((cmd_s1 == salc_pkg::CMD_READ) || wa_q);
		t_lane  = f_hit ? h_lane : (f_inv ? i_lane : m_lane);
		f_ev    = do_fill && !f_inv;
		ev_addr = f_ev ? cur[m_lane].addr : 32'd0;

		wr_row = cur;
		if (cmd_s1 == salc_pkg::CMD_INVAL && f_hit) wr_row[h_lane].valid = 1'b0;
		if (do_fill) begin
			wr_row[t_lane].tag   = tag_s1;
			wr_row[t_lane].addr  = addr_s1;
			wr_row[t_lane].valid = 1'b1;
			wr_row[t_lane].dirty = (cmd_s1 == salc_pkg::CMD_WRITE);
		end
		if (is_acc && f_hit && cmd_s1 == salc_pkg::CMD_WRITE) wr_row[t_lane].dirty = 1'b1;
		old = cur[t_lane].rank;
		if (is_acc && (f_hit || do_fill)) begin
			for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
				if (inset[i] && LW'(i) != t_lane && cur[i].valid && cur[i].rank > old)
					wr_row[i].rank = cur[i].rank - RW'(1);
			end
			wr_row[t_lane].rank = top_rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done         <= 1'b0;
			access_total <= '0;
			miss_total   <= '0;
		end else begin
			done <= ctl.update;
			if (ctl.update && is_acc) begin
				access_total <= access_total + 32'd1;
				if (!f_hit) miss_total <= miss_total + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.update) begin
			hit             <= (is_acc || cmd_s1 == salc_pkg::CMD_INVAL) && f_hit;
			evicted         <= f_ev;
			evicted_address <= ev_addr;
		end
	end

endmodule

[hdl/set_assoc_lru_cache_tags.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags: tag and LRU controller of one cache level
// Looks up reads, writes and invalidates, fills or evicts lines, and keeps
// running access and miss totals.
// ----------------------------------------------------------------------------
// Raise start with cmd and address while busy is low; the access transfers at
// that edge. Each access reads the set row from the tag memory as it
// transfers, then in the look state searches it, updates ranks and writes
// the row back. The result appears on hit, evicted, evicted_address and the
// totals at the edge after the transfer with done high for exactly one cycle;
// the result outputs hold until the next result, but done does not, so
// capture it then. A new access may transfer in the same cycle as done.
// Reset needs no clearing pass: a flag per set row marks rows never written.
// Write configuration only while idle; cfg_ready is always high.
module set_assoc_lru_cache_tags (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic        hit,
	output logic        evicted,
	output logic [31:0] evicted_address,
	output logic [31:0] access_total,
	output logic [31:0] miss_total
);

	salc_pkg::ctl_cmd_t ctl;

	assign cfg_ready = 1'b1;

	// Sequence capture and update
	salc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Hold tags, ranks and totals
	salc_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.cmd             (cmd),
		.address         (address),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.hit             (hit),
		.evicted         (evicted),
		.evicted_address (evicted_address),
		.access_total    (access_total),
		.miss_total      (miss_total)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted access did not go busy");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy) else $error("result not strobed after lookup");
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted |-> !hit) else $error("eviction reported on a hit");

endmodule

[dv/salc_checker.sv]
// ----------------------------------------------------------------------------
// salc_checker: lookup predictor and result scoreboard
// Watches the configuration, access and result channels of the tag and LRU
// controller. It keeps its own copy of the tag store and the totals. It
// predicts each access at its transfer and compares every result strobe
// against the oldest prediction.
// ----------------------------------------------------------------------------
module salc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] address,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        done,
	input  logic        hit,
	input  logic        evicted,
	input  logic [31:0] evicted_address,
	input  logic [31:0] access_total,
	input  logic [31:0] miss_total,
	output int          pending,
	output int          fail_count
);

	typedef struct packed {
		logic        hit;
		logic        evicted;
		logic [31:0] ev_addr;
		logic [31:0] accesses;
		logic [31:0] misses;
	} lookup_t;

	localparam int NLINES = salc_pkg::MAX_SETS * salc_pkg::MAX_WAYS;

	logic [4:0]  size_log2, blk_log2;
	logic [1:0]  way_log2;
	logic        alloc_on_write;
	logic        v_q [NLINES];
	logic        d_q [NLINES];
	logic [2:0]  rk_q [NLINES];
	logic [31:0] tg_q [NLINES];
	logic [31:0] ad_q [NLINES];
	logic [31:0] n_access, n_miss;
	lookup_t     lookups_due [$];

	assign pending = lookups_due.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// Move one way to most recent; younger valid ways drop by one.
	function automatic void promote(input int base, input int ways, input int w);
		logic [2:0] old;
		old = rk_q[base + w];
		for (int i = 0; i < ways; i++)
			if (i != w && v_q[base + i] && rk_q[base + i] > old)
				rk_q[base + i]--;
		rk_q[base + w] = 3'(ways - 1);
	endfunction

	function automatic lookup_t lookup(input salc_pkg::op_t op, input logic [31:0] a);
		lookup_t r;
		int ways, sb, used, shift, base, w, victim;
		logic [31:0] set, tg;
		r = '0;
		ways = 1 << way_log2;
		used = blk_log2 + way_log2;
		sb = (size_log2 > used) ? size_log2 - used : 0;
		if (sb > salc_pkg::SET_W) sb = salc_pkg::SET_W;
		set = (a >> blk_log2) & ((32'd1 << sb) - 1);
		shift = blk_log2 + sb;
		tg = (shift < 32) ? a >> shift : 32'd0;
		base = set * ways;
		w = ways;
		for (int i = 0; i < ways; i++)
			if (w == ways && v_q[base + i] && tg_q[base + i] == tg) w = i;
		if (op == salc_pkg::CMD_INVAL) begin
			if (w < ways) begin
				r.hit = 1'b1;
				v_q[base + w] = 1'b0;
			end
		end else if (op == salc_pkg::CMD_READ || op == salc_pkg::CMD_WRITE) begin
			n_access++;
			if (w < ways) begin
				r.hit = 1'b1;
				promote(base, ways, w);
				if (op == salc_pkg::CMD_WRITE) d_q[base + w] = 1'b1;
			end else begin
				n_miss++;
				if (op == salc_pkg::CMD_READ || alloc_on_write) begin
					victim = ways;
					for (int i = 0; i < ways; i++)
						if (victim == ways && !v_q[base + i]) victim = i;
					if (victim == ways) begin
						victim = 0;
						for (int i = 1; i < ways; i++)
							if (rk_q[base + i] < rk_q[base + victim]) victim = i;
						r.evicted = 1'b1;
						r.ev_addr = ad_q[base + victim];
					end
					tg_q[base + victim] = tg;
					ad_q[base + victim] = a;
					v_q[base + victim] = 1'b1;
					d_q[base + victim] = (op == salc_pkg::CMD_WRITE);
					promote(base, ways, victim);
				end
			end
		end
		r.accesses = n_access;
		r.misses = n_miss;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			size_log2 = 5'd13;
			blk_log2 = 5'd5;
			way_log2 = 2'd1;
			alloc_on_write = 1'b1;
			for (int i = 0; i < NLINES; i++) begin
				v_q[i] = 1'b0;
				d_q[i] = 1'b0;
				rk_q[i] = 3'd0;
			end
			n_access = '0;
			n_miss = '0;
			lookups_due.delete();
			fail_count = 0;
		end else begin
			// Results first: a new access may transfer in the same cycle.
			if (done) begin
				if (lookups_due.size() == 0) begin
					report("unexpected result", 32'd0, 32'd0);
				end else begin
					want = lookups_due.pop_front();
					if (hit !== want.hit) report("hit", hit, want.hit);
					if (evicted !== want.evicted) report("evicted", evicted, want.evicted);
					if (evicted_address !== want.ev_addr)
						report("evicted_address", evicted_address, want.ev_addr);
					if (access_total !== want.accesses)
						report("access_total", access_total, want.accesses);
					if (miss_total !== want.misses)
						report("miss_total", miss_total, want.misses);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (salc_pkg::reg_idx_t'(cfg_index))
					salc_pkg::REG_CACHE_SIZE: size_log2 = cfg_data[4:0];
					salc_pkg::REG_BLOCK:      blk_log2 = cfg_data[4:0];
					salc_pkg::REG_WAY:        way_log2 = cfg_data[1:0];
					salc_pkg::REG_WALLOC:     alloc_on_write = cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy)
				lookups_due.push_back(lookup(salc_pkg::op_t'(cmd), address));
		end
	end

	final begin
		if (lookups_due.size() != 0)
			$display("%0d results never arrived", lookups_due.size());
	end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression for the set-associative tag and LRU controller
// Drives directed and random reads, writes and invalidates over several
// cache geometries. A checker beside the block predicts every result and
// counts mismatches. This top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = salc_pkg::CMD_READ;
	logic [31:0] address = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = salc_pkg::REG_CACHE_SIZE;
	logic [31:0] cfg_data = '0;
	logic        done, hit, evicted;
	logic [31:0] evicted_address, access_total, miss_total;
	int          pending, fail_count;
	int          cycles = 0;
	logic [31:0] addr_pool [16];

	always #1 clk = ~clk;

	set_assoc_lru_cache_tags uut (.*);

	salc_checker chk (.*);

	// Hard stop if the block stalls or loses results.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Hold start until the access transfers. Busy only moves at clock edges,
	// so sample it in the middle of the cycle. Start stays high on return.
	task automatic issue(input salc_pkg::op_t op, input logic [31:0] a);
		logic took;
		start <= 1'b1;
		cmd <= op;
		address <= a;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic rest(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drain every outstanding lookup, then let the pipeline settle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register; random upper bits exercise the whole data bus.
	// Valid stays high on return so that writes can follow back to back.
	task automatic write_reg(input salc_pkg::reg_idx_t idx, input logic [31:0] val);
		logic took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic set_geometry(input int csz, input int blk, input int wb, input int wa);
		drain();
		write_reg(salc_pkg::REG_CACHE_SIZE,
			{27'($urandom_range(0, 32'h7ff_ffff)), 5'(csz)});
		write_reg(salc_pkg::REG_BLOCK,
			{27'($urandom_range(0, 32'h7ff_ffff)), 5'(blk)});
		write_reg(salc_pkg::REG_WAY,
			{30'($urandom_range(0, 32'h3fff_ffff)), 2'(wb)});
		write_reg(salc_pkg::REG_WALLOC,
			{31'($urandom_range(0, 32'h7fff_ffff)), 1'(wa)});
		cfg_valid <= 1'b0;
		@(posedge clk);
		for (int i = 0; i < 16; i++) addr_pool[i] = $urandom;
	endtask

	function automatic salc_pkg::op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 48) return salc_pkg::CMD_READ;
		if (r < 83) return salc_pkg::CMD_WRITE;
		if (r < 96) return salc_pkg::CMD_INVAL;
		return salc_pkg::CMD_NONE;
	endfunction

	// Mostly revisit a small address pool so sets fill, hit and evict.
	task automatic random_phase(input int n, input bit quiet);
		logic [31:0] a;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 8)
				a = addr_pool[$urandom_range(0, 15)] ^ $urandom_range(0, 63);
			else
				a = $urandom;
			issue(pick_op(), a);
			if (!quiet && $urandom_range(0, 5) == 0) rest($urandom_range(1, 7));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset geometry: two ways, tags change at bit 12.
		issue(salc_pkg::CMD_READ, 32'h0000_0000);
		issue(salc_pkg::CMD_READ, 32'h0000_0000);
		issue(salc_pkg::CMD_WRITE, 32'h0000_1004);
		issue(salc_pkg::CMD_READ, 32'h0000_2000);
		issue(salc_pkg::CMD_READ, 32'h0000_1000);
		issue(salc_pkg::CMD_WRITE, 32'h0000_3000);
		issue(salc_pkg::CMD_INVAL, 32'h0000_1000);
		issue(salc_pkg::CMD_INVAL, 32'h0000_1000);
		issue(salc_pkg::CMD_READ, 32'h0000_4000);
		issue(salc_pkg::CMD_NONE, 32'hffff_ffff);
		issue(salc_pkg::CMD_WRITE, 32'hffff_ffff);
		issue(salc_pkg::CMD_READ, 32'hffff_ffe0);
		// Pause until every result is back before going on.
		drain();
		issue(salc_pkg::CMD_READ, 32'h0000_0fff);
		set_geometry(13, 5, 1, 0);
		// Write miss without allocation, then read allocates.
		issue(salc_pkg::CMD_WRITE, 32'h0000_8000);
		issue(salc_pkg::CMD_WRITE, 32'h0000_8000);
		issue(salc_pkg::CMD_READ, 32'h0000_8000);
		issue(salc_pkg::CMD_WRITE, 32'h0000_8000);
		set_geometry(0, 0, 0, 1);
		issue(salc_pkg::CMD_READ, 32'h0000_0001);
		issue(salc_pkg::CMD_READ, 32'h0000_0002);
		issue(salc_pkg::CMD_INVAL, 32'h0000_0002);
		set_geometry(31, 31, 3, 1);
		issue(salc_pkg::CMD_READ, 32'h8000_0000);
		issue(salc_pkg::CMD_WRITE, 32'h1234_5678);

		// Random phases over several geometries, extremes among them.
		set_geometry(13, 5, 1, 1);
		random_phase(PHASE_ITEMS, 1'b0);
		set_geometry(10, 2, 3, 1);
		random_phase(PHASE_ITEMS, 1'b0);
		set_geometry(0, 0, 0, 0);
		random_phase(PHASE_ITEMS / 2, 1'b0);
		set_geometry(27, 16, 3, 0);
		random_phase(PHASE_ITEMS, 1'b0);
		set_geometry(8, 3, 2, 1);
		random_phase(PHASE_ITEMS, 1'b0);
		// Keep the old lines and reinterpret them under a new split.
		set_geometry(12, 4, 1, 1);
		random_phase(PHASE_ITEMS / 2, 1'b0);
		random_phase(PHASE_ITEMS / 2, 1'b1);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
